### hdl/triangle_fragment_shade_defines.svh
// Assertion macros for the triangle fragment shading pipeline
`ifndef TRIANGLE_FRAGMENT_SHADE_DEFINES_SVH
`define TRIANGLE_FRAGMENT_SHADE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// check a condition in the same cycle
`define TFS_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("fragment shade assertion failed");
// check a condition in the cycle after the antecedent
`define TFS_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("fragment shade assertion failed");
`else
`define TFS_ASSERT_IMP(lbl, pre, post)
`define TFS_ASSERT_NXT(lbl, pre, post)
`endif
`endif

### hdl/tfs_pkg.sv
// Shared constants and types for the triangle fragment shading pipeline
package tfs_pkg;
	localparam int PIXEL_COORD_BITS_DEF = 12;
	localparam int POS_FRAC_BITS = 4;
	localparam int VTX_W = 16;
	localparam int CHAN_W = 8;
	localparam int LIGHT_W = 16;
	localparam int LIGHT_FRAC_BITS = 14;
	localparam int COLOR_FRAC_BITS = 8;
	localparam int QUOT_BITS = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 48;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_POS_A = 3'd0;
	localparam cfg_idx_t REG_POS_B = 3'd1;
	localparam cfg_idx_t REG_POS_C = 3'd2;
	localparam cfg_idx_t REG_COL_A = 3'd3;
	localparam cfg_idx_t REG_COL_B = 3'd4;
	localparam cfg_idx_t REG_COL_C = 3'd5;
	localparam cfg_idx_t REG_LIGHT = 3'd6;
endpackage

### hdl/tfs_div.sv
// Pipelined rounded divider, one quotient bit per stage, saturating result
module tfs_div import tfs_pkg::*; #(
	parameter int NUM_W = 55,
	parameter int DEN_W = 35
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [NUM_W-1:0]   num,
	input  logic        [DEN_W-1:0]   den,
	output logic signed [QUOT_BITS:0] quot
);
	localparam int QB = QUOT_BITS;
	localparam int RW = ((NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB) + 1;
	localparam logic signed [QB:0] QMAX = {1'b0, {QB{1'b1}}};
	localparam logic signed [QB:0] QMIN = {1'b1, {QB{1'b0}}};

	logic [RW-1:0]    rem_s [0:QB];
	logic [QB-1:0]    quo_s [0:QB];
	logic [DEN_W-1:0] den_s [0:QB];
	logic             neg_s [0:QB];
	logic             ovf_s [0:QB];

	logic             neg_in;
	logic [NUM_W-1:0] mag_in;
	logic [RW-1:0]    start;

	assign neg_in = num[NUM_W-1];
	assign mag_in = neg_in ? NUM_W'(-num) : NUM_W'(num);
	// add half the divisor for round-to-nearest, ties away from zero
	assign start  = RW'(mag_in) + RW'(den >> 1);

	always_ff @(posedge clk) begin
		logic [RW-1:0] dsh;
		logic          ge;
		if (en) begin
			rem_s[0] <= start;
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg_in;
			ovf_s[0] <= start >= (RW'(den) << QB);
			// each stage resolves one quotient bit, most significant first
			for (int k = 1; k <= QB; k++) begin
				dsh = RW'(den_s[k-1]) << (QB - k);
				ge  = rem_s[k-1] >= dsh;
				rem_s[k] <= ge ? rem_s[k-1] - dsh : rem_s[k-1];
				quo_s[k] <= quo_s[k-1] | (QB'(ge) << (QB - k));
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	always_comb begin
		if (ovf_s[QB])
			quot = neg_s[QB] ? QMIN : QMAX;
		else if (neg_s[QB])
			quot = -$signed({1'b0, quo_s[QB]});
		else
			quot = $signed({1'b0, quo_s[QB]});
	end
endmodule

### hdl/triangle_fragment_shade.sv
// Triangle fragment shading pipeline: edge test, barycentric blend, lighting
//
//   channel  handshake               word
//   pix      pix_valid / pix_ready   pixel_x, pixel_y
//   frag     frag_valid / frag_ready inside_res, degenerate, red, green, blue, alpha
//   cfg      cfg_we                  cfg_idx, cfg_data
//
// One pixel enters per cycle unless frag_ready stalls the output; most of the
// pipeline is the 24 quotient-bit stages of the five barycentric dividers.
// Reset clears all configuration registers and every stage valid bit.
// A stall on frag_ready freezes the whole pipeline; pix_ready is low only then.
`include "triangle_fragment_shade_defines.svh"
module triangle_fragment_shade import tfs_pkg::*; #(
	parameter int PIXEL_COORD_BITS = PIXEL_COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  cfg_idx_t                    cfg_idx,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        pix_valid,
	output logic                        pix_ready,
	input  logic [PIXEL_COORD_BITS-1:0] pixel_x,
	input  logic [PIXEL_COORD_BITS-1:0] pixel_y,
	output logic                        frag_valid,
	input  logic                        frag_ready,
	output logic                        inside_res,
	output logic                        degenerate,
	output logic [CHAN_W-1:0]           red,
	output logic [CHAN_W-1:0]           green,
	output logic [CHAN_W-1:0]           blue,
	output logic [CHAN_W-1:0]           alpha
);
	localparam int CW   = PIXEL_COORD_BITS + POS_FRAC_BITS;
	localparam int DW   = ((CW > VTX_W) ? CW : VTX_W) + 2;
	localparam int VW   = VTX_W + 1;
	localparam int NW   = VW + DW + 1;
	localparam int AW   = 2 * VW + 1;
	localparam int NUMW = NW + LIGHT_W + 3;
	localparam int QB   = QUOT_BITS;
	localparam int PW   = 2 * (QB + 1);
	localparam int SH   = LIGHT_FRAC_BITS + COLOR_FRAC_BITS;

	// configuration
	logic [31:0]           pos_q [0:2];
	logic [31:0]           col_q [0:2];
	logic [3*LIGHT_W-1:0]  light_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				col_q[i] <= '0;
			end
			light_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_POS_A: pos_q[0] <= cfg_data[31:0];
				REG_POS_B: pos_q[1] <= cfg_data[31:0];
				REG_POS_C: pos_q[2] <= cfg_data[31:0];
				REG_COL_A: col_q[0] <= cfg_data[31:0];
				REG_COL_B: col_q[1] <= cfg_data[31:0];
				REG_COL_C: col_q[2] <= cfg_data[31:0];
				REG_LIGHT: light_q  <= cfg_data[3*LIGHT_W-1:0];
				default:   ;
			endcase
		end
	end

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic v_d [0:QB];
	assign en        = !v_s8 || frag_ready;
	assign pix_ready = en;

	// stage 1: differences
	logic signed [VTX_W-1:0] vx [0:2];
	logic signed [VTX_W-1:0] vy [0:2];
	logic signed [DW-1:0]    px, py;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vx[i] = $signed(pos_q[i][VTX_W-1:0]);
			vy[i] = $signed(pos_q[i][2*VTX_W-1:VTX_W]);
		end
		px = $signed(DW'({pixel_x, {POS_FRAC_BITS{1'b0}}}));
		py = $signed(DW'({pixel_y, {POS_FRAC_BITS{1'b0}}}));
	end

	logic signed [VW-1:0] ex_s1 [0:2];
	logic signed [VW-1:0] ey_s1 [0:2];
	logic signed [DW-1:0] qx_s1 [0:2];
	logic signed [DW-1:0] qy_s1 [0:2];
	always_ff @(posedge clk) begin
		if (en) begin
			// edge i runs from vertex i+1 to vertex i+2; pixel taken from vertex i+1
			for (int i = 0; i < 3; i++) begin
				ex_s1[i] <= VW'(vx[(i+2)%3]) - VW'(vx[(i+1)%3]);
				ey_s1[i] <= VW'(vy[(i+2)%3]) - VW'(vy[(i+1)%3]);
				qx_s1[i] <= px - DW'(vx[(i+1)%3]);
				qy_s1[i] <= py - DW'(vy[(i+1)%3]);
			end
		end
	end

	// stage 2: cross products
	logic signed [VW+DW-1:0] pa_s2 [0:2];
	logic signed [VW+DW-1:0] pb_s2 [0:2];
	logic signed [2*VW-1:0]  aa_s2, ab_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pa_s2[i] <= ex_s1[i] * qy_s1[i];
				pb_s2[i] <= ey_s1[i] * qx_s1[i];
			end
			aa_s2 <= ey_s1[2] * ex_s1[1];
			ab_s2 <= ex_s1[2] * ey_s1[1];
		end
	end

	// stage 3: edge functions and area
	logic signed [NW-1:0] n_s3 [0:2];
	logic signed [AW-1:0] area_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				n_s3[i] <= NW'(pa_s2[i]) - NW'(pb_s2[i]);
			area_s3 <= AW'(aa_s2) - AW'(ab_s2);
		end
	end

	// stage 4: inside test, orientation fold
	logic signed [NW-1:0] n_s4 [0:2];
	logic [AW-1:0]        den_s4;
	logic                 in_s4, dg_s4;
	logic                 flip;
	assign flip = area_s3[AW-1];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				n_s4[i] <= flip ? -n_s3[i] : n_s3[i];
			in_s4  <= (!n_s3[0][NW-1] && !n_s3[1][NW-1] && !n_s3[2][NW-1]) ||
			          (n_s3[0][NW-1] && n_s3[1][NW-1] && n_s3[2][NW-1]);
			dg_s4  <= area_s3 == '0;
			// a zero area gets a unit divisor; its colors are forced to zero
			den_s4 <= (area_s3 == '0) ? AW'(1) : (flip ? AW'(-area_s3) : AW'(area_s3));
		end
	end

	// stage 5: weight products
	logic signed [NW+LIGHT_W:0] lp_s5 [0:2];
	logic signed [NW+CHAN_W:0]  cp_s5 [0:3][0:2];
	logic [AW-1:0]              den_s5;
	logic                       in_s5, dg_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				lp_s5[i] <= n_s4[i] * $signed({1'b0, light_q[LIGHT_W*i +: LIGHT_W]});
				for (int c = 0; c < 4; c++)
					cp_s5[c][i] <= n_s4[i] * $signed({1'b0, col_q[i][CHAN_W*c +: CHAN_W]});
			end
			den_s5 <= den_s4;
			in_s5  <= in_s4;
			dg_s5  <= dg_s4;
		end
	end

	// stage 6: numerators
	logic signed [NUMW-1:0] lnum_s6;
	logic signed [NUMW-1:0] cnum_s6 [0:3];
	logic [AW-1:0]          den_s6;
	logic                   in_s6, dg_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			lnum_s6 <= NUMW'(lp_s5[0]) + NUMW'(lp_s5[1]) + NUMW'(lp_s5[2]);
			for (int c = 0; c < 3; c++)
				cnum_s6[c] <= (NUMW'(cp_s5[c][0]) + NUMW'(cp_s5[c][1]) +
				               NUMW'(cp_s5[c][2])) <<< COLOR_FRAC_BITS;
			cnum_s6[3] <= NUMW'(cp_s5[3][0]) + NUMW'(cp_s5[3][1]) + NUMW'(cp_s5[3][2]);
			den_s6 <= den_s5;
			in_s6  <= in_s5;
			dg_s6  <= dg_s5;
		end
	end

	// dividers
	logic signed [QB:0] lq;
	logic signed [QB:0] cq [0:3];

	tfs_div #(.NUM_W(NUMW), .DEN_W(AW)) u_div_light (
		.clk(clk), .en(en), .num(lnum_s6), .den(den_s6), .quot(lq)
	);
	for (genvar c = 0; c < 4; c++) begin : g_div
		tfs_div #(.NUM_W(NUMW), .DEN_W(AW)) u_div (
			.clk(clk), .en(en), .num(cnum_s6[c]), .den(den_s6), .quot(cq[c])
		);
	end

	// flags travel beside the dividers
	logic in_d [0:QB];
	logic dg_d [0:QB];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++)
				v_d[k] <= 1'b0;
		end else if (en) begin
			v_d[0] <= v_s6;
			for (int k = 1; k <= QB; k++)
				v_d[k] <= v_d[k-1];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			in_d[0] <= in_s6;
			dg_d[0] <= dg_s6;
			for (int k = 1; k <= QB; k++) begin
				in_d[k] <= in_d[k-1];
				dg_d[k] <= dg_d[k-1];
			end
		end
	end

	// stage 7: apply light, clamp alpha
	logic signed [PW-1:0] prod_s7 [0:2];
	logic [CHAN_W-1:0]    a_s7;
	logic                 in_s7, dg_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++)
				prod_s7[c] <= cq[c] * lq;
			if (cq[3][QB])
				a_s7 <= '0;
			else if (cq[3] > $signed((QB+1)'({CHAN_W{1'b1}})))
				a_s7 <= '1;
			else
				a_s7 <= cq[3][CHAN_W-1:0];
			in_s7 <= in_d[QB];
			dg_s7 <= dg_d[QB];
		end
	end

	// stage 8: round and saturate
	logic [PW-1:0]     rnd [0:2];
	logic [CHAN_W-1:0] sat [0:2];
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rnd[c] = (PW'(prod_s7[c]) + (PW'(1) << (SH - 1))) >> SH;
			if (prod_s7[c][PW-1])
				sat[c] = '0;
			else if (rnd[c] > PW'({CHAN_W{1'b1}}))
				sat[c] = '1;
			else
				sat[c] = rnd[c][CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_res <= in_s7;
			degenerate <= dg_s7;
			red        <= dg_s7 ? '0 : sat[0];
			green      <= dg_s7 ? '0 : sat[1];
			blue       <= dg_s7 ? '0 : sat[2];
			alpha      <= dg_s7 ? '0 : a_s7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_d[QB];
			v_s8 <= v_s7;
		end
	end

	assign frag_valid = v_s8;

	`TFS_ASSERT_IMP(a_degen_black, frag_valid && degenerate, red == 0 && green == 0 && blue == 0 && alpha == 0)
	`TFS_ASSERT_IMP(a_stall_cause, !pix_ready, frag_valid && !frag_ready)
	`TFS_ASSERT_NXT(a_flow, pix_ready && v_s1, v_s2)
	`TFS_ASSERT_NXT(a_hold_word, frag_valid && !frag_ready, frag_valid)
endmodule
